### sv/dshot_pkg.sv
// ----------------------------------------------------------------------------
// DShot transmitter package
// Shared types, constants and the frame builder for the DShot frame
// transmitter core and its sub-modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package dshot_pkg;

    // Default width of the timing registers and tick counter.
    localparam int TIMING_BITS_DEFAULT = 8;

    // Depth of the queues on either side of the frame engine.
    localparam int QUEUE_DEPTH_DEFAULT = 2;

    // Reset values of the timing registers.
    localparam int RESET_BIT_PERIOD = 27;
    localparam int RESET_ONE_HIGH   = 20;
    localparam int RESET_ZERO_HIGH  = 10;

    // Commands below this value, other than zero, request telemetry.
    localparam logic [10:0] TELEM_LIMIT = 11'd48;

    // Index of the last bit of a frame.
    localparam logic [3:0] LAST_BIT = 4'd15;

    // Width of the configuration address and data.
    localparam int CFG_ADDR_BITS = 4;
    localparam int CFG_DATA_BITS = 32;

    // Byte addresses of the timing registers.
    typedef enum logic [CFG_ADDR_BITS-1:0] {
        ADDR_BIT_PERIOD = 4'h0,
        ADDR_ONE_HIGH   = 4'h4,
        ADDR_ZERO_HIGH  = 4'h8
    } cfg_addr_t;

    // Input item kinds.
    localparam logic OP_TICK = 1'b0;
    localparam logic OP_LOAD = 1'b1;

    // Classified item passed from the front end to the frame engine.
    typedef struct packed {
        logic        is_load;
        logic [15:0] frame;
    } cmd_item_t;

    // Result item produced by the frame engine.
    typedef struct packed {
        logic        pin_level;
        logic        busy_res;
        logic        rejected;
        logic [15:0] frame_word;
    } res_item_t;

    // Build a frame: command, telemetry bit, then the XOR of the three nibbles.
    function automatic logic [15:0] build_frame(input logic [10:0] cmd);
        logic        telem;
        logic [11:0] value;
        logic [3:0]  crc;
        telem = (cmd != 11'd0) && (cmd < TELEM_LIMIT);
        value = {cmd, telem};
        crc   = value[3:0] ^ value[7:4] ^ value[11:8];
        return {value, crc};
    endfunction

endpackage

`default_nettype wire

### sv/dshot_fifo.sv
// ----------------------------------------------------------------------------
// DShot item queue
// Small first-in first-out queue of items with full and empty flags.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module dshot_fifo #(
    parameter int WIDTH = 17,
    parameter int DEPTH = 2
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    input  wire logic [WIDTH-1:0] wdata,
    output logic                  full,
    input  wire logic             pop,
    output logic [WIDTH-1:0]      rdata,
    output logic                  empty
);

    localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_BITS = $clog2(DEPTH + 1);
    localparam logic [PTR_BITS-1:0] LAST_PTR = PTR_BITS'(DEPTH - 1);
    localparam logic [CNT_BITS-1:0] FULL_CNT = CNT_BITS'(DEPTH);

    logic [WIDTH-1:0]    mem_reg [DEPTH];
    logic [PTR_BITS-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_BITS-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_BITS-1:0] count_reg, count_next;
    logic                do_push;
    logic                do_pop;

    assign full    = (count_reg == FULL_CNT);
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rdata   = mem_reg[rd_ptr_reg];

    // Pointer and fill count update, wrapping at the queue depth.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Item storage needs no reset.
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= wdata;
        end
    end

endmodule

`default_nettype wire

### sv/dshot_front.sv
// ----------------------------------------------------------------------------
// DShot front end
// Accepts input items, classifies them as tick or load, builds the frame
// for loads and queues the classified item for the frame engine.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module dshot_front
    import dshot_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        push,
    output logic             full,
    input  wire logic        op,
    input  wire logic [10:0] command,
    input  wire logic        q_pop,
    output cmd_item_t        q_item,
    output logic             q_empty
);

    cmd_item_t in_item;
    logic [$bits(cmd_item_t)-1:0] q_rdata;

    // Classify the item and build the frame for a load.
    always_comb
    begin
        in_item.is_load = (op == OP_LOAD);
        in_item.frame   = build_frame(command);
    end

    dshot_fifo #(
        .WIDTH ($bits(cmd_item_t)),
        .DEPTH (QUEUE_DEPTH)
    ) u_cmd_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .wdata (in_item),
        .full  (full),
        .pop   (q_pop),
        .rdata (q_rdata),
        .empty (q_empty)
    );

    assign q_item = cmd_item_t'(q_rdata);

endmodule

`default_nettype wire

### sv/dshot_back.sv
// ----------------------------------------------------------------------------
// DShot frame engine
// Carries out classified items, one per cycle while the result queue has
// room: latches frames, times the pin per tick, queues one result per item.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module dshot_back
    import dshot_pkg::*;
#(
    parameter int TIMING_BITS = TIMING_BITS_DEFAULT,
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic [TIMING_BITS-1:0] bit_period,
    input  wire logic [TIMING_BITS-1:0] one_high,
    input  wire logic [TIMING_BITS-1:0] zero_high,
    input  wire cmd_item_t              q_item,
    input  wire logic                   q_empty,
    output logic                        q_pop,
    input  wire logic                   pop,
    output res_item_t                   res_item,
    output logic                        empty
);

    logic [15:0]            frame_reg, frame_next;
    logic [3:0]             bit_idx_reg, bit_idx_next;
    logic [TIMING_BITS-1:0] tick_reg, tick_next;
    logic                   sending_reg, sending_next;

    logic                   res_full;
    res_item_t              res_next;
    logic [$bits(res_item_t)-1:0] res_rdata;

    logic                   cur_bit;
    logic [TIMING_BITS-1:0] high_sel;
    logic [TIMING_BITS-1:0] high_sat;
    logic [TIMING_BITS:0]   tick_inc;
    logic                   bit_end;

    // Take an item whenever the result queue has room.
    assign q_pop = !q_empty && !res_full;

    // Bit timing for the bit now on the line.
    always_comb
    begin
        cur_bit  = frame_reg[~bit_idx_reg];
        high_sel = cur_bit ? one_high : zero_high;
        high_sat = (high_sel > bit_period) ? bit_period : high_sel;
        tick_inc = {1'b0, tick_reg} + 1'b1;
        bit_end  = (tick_inc >= {1'b0, bit_period});
    end

    // State update and result for the item being carried out.
    always_comb
    begin
        frame_next   = frame_reg;
        bit_idx_next = bit_idx_reg;
        tick_next    = tick_reg;
        sending_next = sending_reg;
        res_next.pin_level = 1'b0;
        res_next.rejected  = 1'b0;
        if (q_pop)
        begin
            if (q_item.is_load)
            begin
                if (sending_reg)
                begin
                    res_next.rejected = 1'b1;
                end
                else
                begin
                    frame_next   = q_item.frame;
                    bit_idx_next = '0;
                    tick_next    = '0;
                    sending_next = 1'b1;
                end
            end
            else if (sending_reg)
            begin
                res_next.pin_level = (tick_reg < high_sat);
                if (bit_end)
                begin
                    tick_next = '0;
                    if (bit_idx_reg == LAST_BIT)
                    begin
                        bit_idx_next = '0;
                        sending_next = 1'b0;
                    end
                    else
                    begin
                        bit_idx_next = bit_idx_reg + 1'b1;
                    end
                end
                else
                begin
                    tick_next = tick_inc[TIMING_BITS-1:0];
                end
            end
        end
        res_next.busy_res   = sending_next;
        res_next.frame_word = frame_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_reg   <= '0;
            bit_idx_reg <= '0;
            tick_reg    <= '0;
            sending_reg <= 1'b0;
        end
        else
        begin
            frame_reg   <= frame_next;
            bit_idx_reg <= bit_idx_next;
            tick_reg    <= tick_next;
            sending_reg <= sending_next;
        end
    end

    // Result queue towards the consumer.
    dshot_fifo #(
        .WIDTH ($bits(res_item_t)),
        .DEPTH (QUEUE_DEPTH)
    ) u_res_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (q_pop),
        .wdata (res_next),
        .full  (res_full),
        .pop   (pop),
        .rdata (res_rdata),
        .empty (empty)
    );

    assign res_item = res_item_t'(res_rdata);

endmodule

`default_nettype wire

### sv/dshot_frame_transmitter_core.sv
// ----------------------------------------------------------------------------
// DShot frame transmitter core
// Builds 16-bit DShot command frames and times the output pin per tick item.
// ----------------------------------------------------------------------------
// Each input item (a tick or a load) yields exactly one result item. The core
// takes one item every clock cycle while full is low. An item is classified
// and its frame built as it enters the input queue; the frame engine carries
// it out once it heads that queue and the output queue has room, and writes
// its result into the output queue. Both queues are QUEUE_DEPTH items
// deep, so a stalled consumer fills the output queue and then the input queue
// before full is raised. The timing registers (bit period, one and zero high
// times) sit on the APB port at byte addresses 0x0, 0x4 and 0x8 and should
// only be written while no item is in flight.
`timescale 1ns / 1ps
`default_nettype none

module dshot_frame_transmitter_core
    import dshot_pkg::*;
#(
    parameter int TIMING_BITS = TIMING_BITS_DEFAULT,
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
) (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    // Input queue side
    input  wire logic                     push,
    output logic                          full,
    input  wire logic                     op,
    input  wire logic [10:0]              command,
    // Result queue side
    input  wire logic                     pop,
    output logic                          empty,
    output logic                          pin_level,
    output logic                          busy_res,
    output logic                          rejected,
    output logic [15:0]                   frame_word,
    // Configuration port
    input  wire logic                     psel,
    input  wire logic                     penable,
    input  wire logic                     pwrite,
    input  wire logic [CFG_ADDR_BITS-1:0] paddr,
    input  wire logic [CFG_DATA_BITS-1:0] pwdata,
    output logic [CFG_DATA_BITS-1:0]      prdata,
    output logic                          pready
);

    logic [TIMING_BITS-1:0] bit_period_reg, bit_period_next;
    logic [TIMING_BITS-1:0] one_high_reg, one_high_next;
    logic [TIMING_BITS-1:0] zero_high_reg, zero_high_next;
    logic                   cfg_write;

    cmd_item_t              cmd_item;
    logic                   cmd_empty;
    logic                   cmd_pop;
    res_item_t              res_item;

    // Configuration registers.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_comb
    begin
        bit_period_next = bit_period_reg;
        one_high_next   = one_high_reg;
        zero_high_next  = zero_high_reg;
        if (cfg_write)
        begin
            unique case (paddr)
                ADDR_BIT_PERIOD: bit_period_next = pwdata[TIMING_BITS-1:0];
                ADDR_ONE_HIGH:   one_high_next   = pwdata[TIMING_BITS-1:0];
                ADDR_ZERO_HIGH:  zero_high_next  = pwdata[TIMING_BITS-1:0];
                default:         ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bit_period_reg <= TIMING_BITS'(RESET_BIT_PERIOD);
            one_high_reg   <= TIMING_BITS'(RESET_ONE_HIGH);
            zero_high_reg  <= TIMING_BITS'(RESET_ZERO_HIGH);
        end
        else
        begin
            bit_period_reg <= bit_period_next;
            one_high_reg   <= one_high_next;
            zero_high_reg  <= zero_high_next;
        end
    end

    // Register read-back.
    always_comb
    begin
        unique case (paddr)
            ADDR_BIT_PERIOD: prdata = CFG_DATA_BITS'(bit_period_reg);
            ADDR_ONE_HIGH:   prdata = CFG_DATA_BITS'(one_high_reg);
            ADDR_ZERO_HIGH:  prdata = CFG_DATA_BITS'(zero_high_reg);
            default:         prdata = '0;
        endcase
    end

    // Front end: accept and classify.
    dshot_front #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .full    (full),
        .op      (op),
        .command (command),
        .q_pop   (cmd_pop),
        .q_item  (cmd_item),
        .q_empty (cmd_empty)
    );

    // Frame engine and result queue.
    dshot_back #(
        .TIMING_BITS (TIMING_BITS),
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .bit_period (bit_period_reg),
        .one_high   (one_high_reg),
        .zero_high  (zero_high_reg),
        .q_item     (cmd_item),
        .q_empty    (cmd_empty),
        .q_pop      (cmd_pop),
        .pop        (pop),
        .res_item   (res_item),
        .empty      (empty)
    );

    assign pin_level  = res_item.pin_level;
    assign busy_res   = res_item.busy_res;
    assign rejected   = res_item.rejected;
    assign frame_word = res_item.frame_word;

    // The engine never takes an item from an empty input queue.
    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !(cmd_pop && cmd_empty))
        else $error("frame engine took an item from an empty queue");

    // A rejected load leaves the frame in progress, so busy must be set.
    a_reject_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && rejected) |-> busy_res)
        else $error("rejected load reported while idle");

    // A rejected load never appears with the pin driven high.
    a_reject_pin_low: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && rejected) |-> !pin_level)
        else $error("pin driven high on a load item");

endmodule

`default_nettype wire

### verif/dshot_frame_transmitter_core_tb.sv
// ----------------------------------------------------------------------------
// DShot frame transmitter core testbench
// Drives load and tick items through the input queue and programs the timing
// registers over APB. A line predictor keeps its own copy of the frame state
// and works out the expected result of every accepted item. A separate
// process pops results and compares them field by field, in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dshot_frame_transmitter_core_tb;

    import dshot_pkg::*;

    localparam int TB_TIMING   = TIMING_BITS_DEFAULT;
    localparam int HOLD_CYCLES = 120;
    localparam int DRAIN_WAIT  = 8;
    localparam int CYCLE_LIMIT = 400000;
    localparam int REPORT_MAX  = 20;

    // Address with no register behind it; writes there must be ignored.
    localparam logic [CFG_ADDR_BITS-1:0] ADDR_UNUSED = 4'hC;

    // Clock, reset and block inputs, all known from time zero.
    logic                     clk     = 1'b0;
    logic                     rst_n   = 1'b0;
    logic                     push    = 1'b0;
    logic                     op      = OP_TICK;
    logic [10:0]              command = '0;
    logic                     pop     = 1'b0;
    logic                     psel    = 1'b0;
    logic                     penable = 1'b0;
    logic                     pwrite  = 1'b0;
    logic [CFG_ADDR_BITS-1:0] paddr   = '0;
    logic [CFG_DATA_BITS-1:0] pwdata  = '0;

    // Block outputs.
    logic                     full;
    logic                     empty;
    logic                     pin_level;
    logic                     busy_res;
    logic                     rejected;
    logic [15:0]              frame_word;
    logic [CFG_DATA_BITS-1:0] prdata;
    logic                     pready;

    // Predicted frame state and timing registers.
    logic [15:0]          tx_frame;
    logic [3:0]           tx_bit;
    logic [TB_TIMING-1:0] tx_ticks;
    bit                   tx_active;
    logic [TB_TIMING-1:0] reg_period;
    logic [TB_TIMING-1:0] reg_one;
    logic [TB_TIMING-1:0] reg_zero;

    // Expected line results, oldest first.
    res_item_t expected_lines[$];
    res_item_t got_line;
    res_item_t want_line;

    int failures      = 0;
    int cycle_count   = 0;
    int hold_requests = 0;
    int holds_served  = 0;
    int stall_left    = 0;
    bit idle_on       = 1'b1;

    dshot_frame_transmitter_core uut (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .full       (full),
        .op         (op),
        .command    (command),
        .pop        (pop),
        .empty      (empty),
        .pin_level  (pin_level),
        .busy_res   (busy_res),
        .rejected   (rejected),
        .frame_word (frame_word),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    // 12 ns clock.
    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    // Watchdog on the total run length.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    // Frame for a command: command, telemetry request, then the nibble XOR.
    function automatic logic [15:0] frame_for(input logic [10:0] cmd);
        logic [11:0] word;
        logic [3:0]  sum;
        word = {cmd, (cmd != 11'd0) && (cmd < TELEM_LIMIT)};
        sum  = '0;
        for (int n = 0; n < 3; n++)
            sum ^= word[n*4 +: 4];
        return {word, sum};
    endfunction

    // Advances the predicted frame state by one item and returns its result.
    function automatic res_item_t line_after_item(input logic item_op,
                                                  input logic [10:0] item_cmd);
        res_item_t            line;
        logic [TB_TIMING-1:0] high_ticks;
        line = '0;
        if (item_op == OP_LOAD)
        begin
            if (tx_active)
                line.rejected = 1'b1;
            else
            begin
                tx_frame  = frame_for(item_cmd);
                tx_bit    = '0;
                tx_ticks  = '0;
                tx_active = 1'b1;
            end
        end
        else if (tx_active)
        begin
            high_ticks = tx_frame[LAST_BIT - tx_bit] ? reg_one : reg_zero;
            if (high_ticks > reg_period)
                high_ticks = reg_period;
            line.pin_level = (tx_ticks < high_ticks);
            // The bit ends once the count reaches the period, even if the
            // period has just been lowered below the count.
            if (int'(tx_ticks) + 1 >= int'(reg_period))
            begin
                tx_ticks = '0;
                if (tx_bit >= LAST_BIT)
                begin
                    tx_bit    = '0;
                    tx_active = 1'b0;
                end
                else
                    tx_bit = tx_bit + 4'd1;
            end
            else
                tx_ticks = tx_ticks + 1'b1;
        end
        line.busy_res   = tx_active;
        line.frame_word = tx_frame;
        return line;
    endfunction

    task automatic report_field(input string field, input logic [15:0] want,
                                input logic [15:0] got);
        if (want !== got)
        begin
            failures++;
            if (failures <= REPORT_MAX)
                $display("%0t ns: %s mismatch, expected 0x%0h, actual 0x%0h",
                         $time, field, want, got);
        end
    endtask

    // Result side: check each popped item, then decide pop for the next cycle.
    always @(posedge clk)
    begin
        if (pop && !empty)
        begin
            got_line = {pin_level, busy_res, rejected, frame_word};
            if (expected_lines.size() == 0)
            begin
                failures++;
                if (failures <= REPORT_MAX)
                    $display("%0t ns: result with nothing expected, expected none, actual 0x%0h",
                             $time, got_line);
            end
            else
            begin
                want_line = expected_lines.pop_front();
                report_field("pin_level", 16'(want_line.pin_level),
                             16'(got_line.pin_level));
                report_field("busy_res", 16'(want_line.busy_res),
                             16'(got_line.busy_res));
                report_field("rejected", 16'(want_line.rejected),
                             16'(got_line.rejected));
                report_field("frame_word", want_line.frame_word, got_line.frame_word);
            end
        end
        if (hold_requests != holds_served)
        begin
            holds_served = hold_requests;
            stall_left   = HOLD_CYCLES;
        end
        if (stall_left > 0)
        begin
            stall_left--;
            pop <= 1'b0;
        end
        else if (idle_on && $urandom_range(0, 5) == 0)
        begin
            stall_left = $urandom_range(0, 4);
            pop <= 1'b0;
        end
        else
            pop <= 1'b1;
    end

    // Offers one item, waits for it to be taken and records its prediction.
    // push is left high so that back-to-back items need no gap.
    task automatic send_item(input logic item_op, input logic [10:0] item_cmd);
        int gap;
        gap = 0;
        if (idle_on && $urandom_range(0, 5) == 0)
            gap = $urandom_range(1, 5);
        if (gap > 0)
        begin
            push <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        push    <= 1'b1;
        op      <= item_op;
        command <= item_cmd;
        @(posedge clk);
        while (full)
            @(posedge clk);
        expected_lines.push_back(line_after_item(item_op, item_cmd));
    endtask

    // Stops offering items and waits until every result has come back.
    task automatic settle_queue();
        push <= 1'b0;
        @(posedge clk);
        while (expected_lines.size() != 0)
            @(posedge clk);
    endtask

    task automatic finish_frame();
        while (tx_active)
            send_item(OP_TICK, 11'($urandom));
    endtask

    // Commands weighted towards the telemetry boundaries and the range ends.
    function automatic logic [10:0] pick_command();
        case ($urandom_range(0, 7))
            0: return 11'd0;
            1: return 11'd1;
            2: return 11'd47;
            3: return 11'd48;
            4: return 11'd2047;
            5: return 11'($urandom_range(2, 46));
            default: return 11'($urandom);
        endcase
    endfunction

    task automatic write_timing(input logic [CFG_ADDR_BITS-1:0] addr,
                                input logic [CFG_DATA_BITS-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (addr)
            ADDR_BIT_PERIOD: reg_period = data[TB_TIMING-1:0];
            ADDR_ONE_HIGH:   reg_one    = data[TB_TIMING-1:0];
            ADDR_ZERO_HIGH:  reg_zero   = data[TB_TIMING-1:0];
            default: ;
        endcase
        @(posedge clk);
    endtask

    task automatic check_register(input logic [CFG_ADDR_BITS-1:0] addr);
        logic [CFG_DATA_BITS-1:0] want;
        case (addr)
            ADDR_BIT_PERIOD: want = CFG_DATA_BITS'(reg_period);
            ADDR_ONE_HIGH:   want = CFG_DATA_BITS'(reg_one);
            ADDR_ZERO_HIGH:  want = CFG_DATA_BITS'(reg_zero);
            default:         want = '0;
        endcase
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= addr;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        if (prdata !== want)
        begin
            failures++;
            $display("%0t ns: register 0x%0h mismatch, expected 0x%0h, actual 0x%0h",
                     $time, addr, want, prdata);
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    // Reset values read back, a write to the unused address changes nothing,
    // and ticks with no frame keep the line low.
    task automatic test_idle_and_readback();
        check_register(ADDR_BIT_PERIOD);
        check_register(ADDR_ONE_HIGH);
        check_register(ADDR_ZERO_HIGH);
        write_timing(ADDR_UNUSED, 32'hFFFF_FFFF);
        check_register(ADDR_BIT_PERIOD);
        check_register(ADDR_ONE_HIGH);
        check_register(ADDR_ZERO_HIGH);
        send_item(OP_TICK, 11'h7FF);
        send_item(OP_TICK, 11'h000);
        settle_queue();
    endtask

    // Single-tick bits with saturated high times, then a period of zero
    // (written with only bit 8 set) which keeps the line low.
    task automatic test_short_periods();
        write_timing(ADDR_BIT_PERIOD, 32'd1);
        write_timing(ADDR_ONE_HIGH, 32'd255);
        write_timing(ADDR_ZERO_HIGH, 32'd255);
        check_register(ADDR_ONE_HIGH);
        send_item(OP_LOAD, 11'd1);
        send_item(OP_LOAD, 11'd48);
        finish_frame();
        send_item(OP_TICK, 11'h7FF);
        settle_queue();
        write_timing(ADDR_BIT_PERIOD, 32'h0000_0100);
        check_register(ADDR_BIT_PERIOD);
        send_item(OP_LOAD, 11'd2047);
        send_item(OP_LOAD, 11'd0);
        finish_frame();
        settle_queue();
    endtask

    // The receiver holds off for a long stretch during a frame at reset
    // timing, so both queues fill and the input side stalls.
    task automatic test_output_backpressure();
        hold_requests <= hold_requests + 1;
        send_item(OP_LOAD, 11'd47);
        finish_frame();
        settle_queue();
    endtask

    // Longest period, then the period is cut below the current tick count
    // in the middle of the frame.
    task automatic test_mid_frame_change();
        write_timing(ADDR_BIT_PERIOD, 32'd255);
        write_timing(ADDR_ONE_HIGH, 32'd255);
        write_timing(ADDR_ZERO_HIGH, 32'd1);
        send_item(OP_LOAD, pick_command());
        repeat (40) send_item(OP_TICK, 11'($urandom));
        settle_queue();
        write_timing(ADDR_BIT_PERIOD, 32'd3);
        write_timing(ADDR_ONE_HIGH, 32'd2);
        finish_frame();
        settle_queue();
    endtask

    // Mostly whole frames with random commands and the odd rejected load,
    // mixed with short runs of random items.
    task automatic test_random_timing(input int period, input int one_t, input int zero_t,
                                      input int n_items);
        int sent;
        settle_queue();
        write_timing(ADDR_BIT_PERIOD, {24'($urandom), 8'(period)});
        write_timing(ADDR_ONE_HIGH, {24'($urandom), 8'(one_t)});
        write_timing(ADDR_ZERO_HIGH, {24'($urandom), 8'(zero_t)});
        sent = 0;
        while (sent < n_items)
        begin
            if ($urandom_range(0, 9) < 8)
            begin
                finish_frame();
                send_item(OP_LOAD, pick_command());
                sent++;
                while (tx_active)
                begin
                    if ($urandom_range(0, 24) == 0)
                        send_item(OP_LOAD, pick_command());
                    send_item(OP_TICK, 11'($urandom));
                    sent++;
                end
                repeat ($urandom_range(0, 2)) send_item(OP_TICK, 11'($urandom));
            end
            else
            begin
                repeat ($urandom_range(1, 8))
                begin
                    send_item(1'($urandom_range(0, 1)), pick_command());
                    sent++;
                end
            end
        end
        settle_queue();
    endtask

    initial
    begin
        tx_frame   = '0;
        tx_bit     = '0;
        tx_ticks   = '0;
        tx_active  = 1'b0;
        reg_period = TB_TIMING'(RESET_BIT_PERIOD);
        reg_one    = TB_TIMING'(RESET_ONE_HIGH);
        reg_zero   = TB_TIMING'(RESET_ZERO_HIGH);
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_idle_and_readback();
        test_output_backpressure();
        test_short_periods();
        test_mid_frame_change();
        test_random_timing(2, 1, 255, 40);
        test_random_timing(3, 2, 1, 40);
        test_random_timing($urandom_range(2, 6), $urandom_range(1, 8),
                           $urandom_range(1, 8), 40);
        test_random_timing($urandom_range(2, 6), $urandom_range(1, 8),
                           $urandom_range(1, 8), 40);
        // Last part runs at full rate on both sides.
        idle_on = 1'b0;
        test_random_timing(4, 3, 1, 40);

        settle_queue();
        repeat (DRAIN_WAIT) @(posedge clk);
        if (failures == 0 && expected_lines.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

### filelist.f
sv/dshot_pkg.sv
sv/dshot_fifo.sv
sv/dshot_front.sv
sv/dshot_back.sv
sv/dshot_frame_transmitter_core.sv
verif/dshot_frame_transmitter_core_tb.sv
